FILE: sv/gcne_pkg.sv
`default_nettype none
package gcne_pkg;

   localparam int CHANNELS      = 16;
   localparam int UPDATE_PERIOD = 64;
   localparam int DEADBAND_LSB  = 3;

   localparam int CH_W     = 4;
   localparam int SLOTS    = 1 << CH_W;
   localparam int PHASE_W  = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;

   localparam logic [CH_W-1:0] CHAN_LAST = CH_W'(SLOTS - 1);

   localparam logic signed [19:0] GATE_ON_Q  = 20'sd16384;
   localparam logic signed [19:0] GATE_OFF_Q = 20'sd1638;
   localparam logic [14:0] FULL_Q     = 15'd16384;
   localparam logic [18:0] DUR_MIN_Q  = 19'd16;
   localparam logic [18:0] DUR_MAX_Q  = 19'd491520;
   localparam logic [13:0] BEND_MAX   = 14'd12288;
   localparam logic [19:0] RECIP      = 20'd838861;

   localparam logic [1:0] EV_ON     = 2'd0;
   localparam logic [1:0] EV_OFF    = 2'd1;
   localparam logic [1:0] EV_UPDATE = 2'd2;

   localparam logic [1:0] LN_BEND   = 2'd0;
   localparam logic [1:0] LN_PRESS  = 2'd1;
   localparam logic [1:0] LN_TIMBRE = 2'd2;

   localparam logic [2:0] CSR_ENDS_AT_GATE     = 3'd0;
   localparam logic [2:0] CSR_BEND_RANGE       = 3'd1;
   localparam logic [2:0] CSR_LEVEL_DEFAULT    = 3'd2;
   localparam logic [2:0] CSR_PAN_DEFAULT      = 3'd3;
   localparam logic [2:0] CSR_DURATION_DEFAULT = 3'd4;
   localparam logic [2:0] CSR_SAMPLE_RATE      = 3'd5;
   localparam logic [2:0] CSR_JACKS            = 3'd6;

   localparam int JACK_LEVEL    = 0;
   localparam int JACK_DURATION = 1;
   localparam int JACK_PAN      = 2;
   localparam int JACK_PRESSURE = 3;
   localparam int JACK_TIMBRE   = 4;

   // event bits in delivery order
   localparam int EVB_OFF_OLD  = 0;
   localparam int EVB_ON       = 1;
   localparam int EVB_OFF_NEW  = 2;
   localparam int EVB_BEND     = 3;
   localparam int EVB_PRESSURE = 4;
   localparam int EVB_TIMBRE   = 5;

   typedef struct packed {
      logic                note_on;
      logic                gate_up;
      logic [31:0]         handle;
      logic signed [19:0]  held_pitch;
      logic [23:0]         age;
      logic [23:0]         length;
      logic signed [20:0]  bend_sent;
      logic [14:0]         pressure_sent;
      logic [14:0]         timbre_sent;
      logic                ever_sent;
   } chan_state_type;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic                active;
      logic signed [19:0]  gate;
      logic signed [19:0]  pitch;
      logic signed [19:0]  level;
      logic signed [19:0]  duration;
      logic signed [19:0]  pan;
      logic signed [19:0]  pressure;
      logic signed [19:0]  timbre;
   } item_type;

   typedef struct packed {
      logic [14:0]         level;
      logic [18:0]         duration;
      logic signed [15:0]  pan;
      logic [23:0]         length;
      logic [14:0]         pressure;
      logic [14:0]         timbre;
   } conv_type;

   typedef struct packed {
      logic                ends_at_gate;
      logic [13:0]         bend_range;
      logic [14:0]         level_default;
      logic signed [15:0]  pan_default;
      logic [18:0]         duration_default;
      logic [17:0]         sample_rate;
      logic [4:0]          jacks;
   } cfg_type;

   typedef struct packed {
      logic [5:0]          mask;
      logic [31:0]         handle_old;
      logic [31:0]         handle_new;
      logic signed [19:0]  pitch;
      logic [14:0]         level;
      logic [18:0]         duration;
      logic signed [15:0]  pan;
      logic [13:0]         bend_range;
      logic signed [20:0]  bend_value;
      logic [14:0]         pressure;
      logic [14:0]         timbre;
   } bundle_type;

   typedef struct packed {
      logic write;
      logic rise;
   } upd_ctl_type;

   // volts / 10 rounded, clamped to 0..1.0
   function automatic logic [14:0] tenth_frac(input logic signed [19:0] v);
      logic [19:0] x;
      logic [39:0] p;
      logic [16:0] q;
      x = v + 20'd5;
      p = 40'(x) * 40'(RECIP);
      q = p[39:23];
      if (v <= 20'sd0) begin
         return '0;
      end else if (q > 17'(FULL_Q)) begin
         return FULL_Q;
      end
      return q[14:0];
   endfunction

   // volts / 5 rounded away from zero on ties, clamped to +-1.0
   function automatic logic signed [15:0] fifth_signed(input logic signed [19:0] v);
      logic signed [20:0] vs;
      logic [20:0] m;
      logic [20:0] x;
      logic [40:0] p;
      logic [18:0] q;
      logic [14:0] c;
      vs = 21'(v);
      m  = v[19] ? 21'(-vs) : vs;
      x  = m + 21'd2;
      p  = 41'(x) * 41'(RECIP);
      q  = p[40:22];
      c  = (q > 19'(FULL_Q)) ? FULL_Q : q[14:0];
      return v[19] ? 16'(-$signed({1'b0, c})) : $signed({1'b0, c});
   endfunction

   function automatic logic moved(input logic signed [21:0] a, input logic signed [21:0] b);
      logic signed [21:0] d;
      d = a - b;
      return (d > $signed(22'(DEADBAND_LSB))) || (d < -$signed(22'(DEADBAND_LSB)));
   endfunction

endpackage
`default_nettype wire

FILE: sv/gcne_ram.sv
`default_nettype none
module gcne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: sv/gcne_conv.sv
`default_nettype none
module gcne_conv (
   input  wire gcne_pkg::item_type  item,
   input  wire gcne_pkg::cfg_type   cfg,
   output gcne_pkg::conv_type       conv
);
   logic [18:0] dur;
   logic [36:0] prod;
   logic [37:0] rounded;
   logic [23:0] len;

   always_comb begin
      if (cfg.jacks[gcne_pkg::JACK_DURATION]) begin
         if (item.duration < $signed({1'b0, gcne_pkg::DUR_MIN_Q})) begin
            dur = gcne_pkg::DUR_MIN_Q;
         end else if (item.duration > $signed({1'b0, gcne_pkg::DUR_MAX_Q})) begin
            dur = gcne_pkg::DUR_MAX_Q;
         end else begin
            dur = item.duration[18:0];
         end
      end else begin
         dur = cfg.duration_default;
      end
      prod    = 37'(dur) * 37'(cfg.sample_rate);
      rounded = 38'(prod) + 38'd8192;
      len     = rounded[37:14];
      if (len == '0) begin
         len = 24'd1;
      end
   end

   always_comb begin
      conv.level    = cfg.jacks[gcne_pkg::JACK_LEVEL] ?
                      gcne_pkg::tenth_frac(item.level) : cfg.level_default;
      conv.pan      = cfg.jacks[gcne_pkg::JACK_PAN] ?
                      gcne_pkg::fifth_signed(item.pan) : cfg.pan_default;
      conv.duration = dur;
      conv.length   = len;
      conv.pressure = gcne_pkg::tenth_frac(item.pressure);
      conv.timbre   = gcne_pkg::tenth_frac(item.timbre);
   end
endmodule
`default_nettype wire

FILE: sv/gcne_update.sv
`default_nettype none
module gcne_update (
   input  wire gcne_pkg::chan_state_type st,
   input  wire gcne_pkg::item_type       item,
   input  wire gcne_pkg::conv_type       conv,
   input  wire gcne_pkg::cfg_type        cfg,
   input  wire logic                     update,
   input  wire logic [31:0]              next_handle,
   output gcne_pkg::chan_state_type      st_new,
   output gcne_pkg::bundle_type          bundle,
   output gcne_pkg::upd_ctl_type         ctl
);
   logic in_use;
   logic gate_new;
   logic rise;
   logic on1;
   logic off_new;
   logic upd;
   logic signed [20:0] dv;
   logic ev_bend;
   logic ev_press;
   logic ev_timbre;
   gcne_pkg::chan_state_type s1;

   always_comb begin
      in_use   = {1'b0, item.channel} < 5'(gcne_pkg::CHANNELS);
      gate_new = st.gate_up ? !(item.gate < gcne_pkg::GATE_OFF_Q)
                            : (item.gate >= gcne_pkg::GATE_ON_Q);
      rise     = item.active && !st.gate_up && gate_new;

      s1 = st;
      if (rise) begin
         s1.handle     = next_handle;
         s1.held_pitch = item.pitch;
         s1.note_on    = 1'b1;
         s1.age        = '0;
         s1.length     = conv.length;
         s1.bend_sent  = '0;
         s1.ever_sent  = 1'b0;
      end
      on1     = s1.note_on;
      s1.age  = on1 ? s1.age + 24'd1 : s1.age;
      off_new = item.active && on1 &&
                ((!gate_new && cfg.ends_at_gate) || (s1.age >= s1.length));
      s1.note_on = on1 && !off_new;
      s1.gate_up = gate_new;

      upd = item.active && s1.note_on && update;
      dv  = 21'(item.pitch) - 21'(s1.held_pitch);
      ev_bend   = upd && (!s1.ever_sent || gcne_pkg::moved(22'(dv), 22'(s1.bend_sent)));
      ev_press  = upd && cfg.jacks[gcne_pkg::JACK_PRESSURE] &&
                  (!s1.ever_sent ||
                   gcne_pkg::moved($signed(22'(conv.pressure)), $signed(22'(s1.pressure_sent))));
      ev_timbre = upd && cfg.jacks[gcne_pkg::JACK_TIMBRE] &&
                  (!s1.ever_sent ||
                   gcne_pkg::moved($signed(22'(conv.timbre)), $signed(22'(s1.timbre_sent))));
      if (ev_bend) begin
         s1.bend_sent = dv;
      end
      if (ev_press) begin
         s1.pressure_sent = conv.pressure;
      end
      if (ev_timbre) begin
         s1.timbre_sent = conv.timbre;
      end
      if (upd) begin
         s1.ever_sent = 1'b1;
      end

      // inactive channel: drop the note and the gate, keep the rest
      if (!item.active) begin
         s1 = st;
         s1.note_on = 1'b0;
         s1.gate_up = 1'b0;
      end
      st_new = s1;

      bundle.mask = '0;
      bundle.mask[gcne_pkg::EVB_OFF_OLD]  = in_use && st.note_on && (!item.active || rise);
      bundle.mask[gcne_pkg::EVB_ON]       = in_use && rise;
      bundle.mask[gcne_pkg::EVB_OFF_NEW]  = in_use && off_new;
      bundle.mask[gcne_pkg::EVB_BEND]     = in_use && ev_bend;
      bundle.mask[gcne_pkg::EVB_PRESSURE] = in_use && ev_press;
      bundle.mask[gcne_pkg::EVB_TIMBRE]   = in_use && ev_timbre;
      bundle.handle_old = st.handle;
      bundle.handle_new = s1.handle;
      bundle.pitch      = item.pitch;
      bundle.level      = conv.level;
      bundle.duration   = conv.duration;
      bundle.pan        = conv.pan;
      bundle.bend_range = cfg.bend_range;
      bundle.bend_value = dv;
      bundle.pressure   = conv.pressure;
      bundle.timbre     = conv.timbre;

      ctl.write = in_use;
      ctl.rise  = in_use && rise;
   end
endmodule
`default_nettype wire

FILE: sv/gcne_emit.sv
`default_nettype none
module gcne_emit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire gcne_pkg::bundle_type bundle,
   output logic                      ready,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_event_kind,
   output logic [31:0]               rsp_note_handle,
   output logic [1:0]                rsp_lane,
   output logic signed [20:0]        rsp_update_value,
   output logic signed [19:0]        rsp_note_pitch,
   output logic [14:0]               rsp_note_level,
   output logic [18:0]               rsp_note_duration,
   output logic signed [15:0]        rsp_note_pan,
   output logic [13:0]               rsp_note_bend_range,
   output logic                      rsp_last
);
   logic                 busy_ff;
   gcne_pkg::bundle_type hold_ff;
   logic                 out_free;
   logic                 fire;
   logic [5:0]           sel;
   logic [5:0]           rem;
   logic [1:0]           kind_in;
   logic [31:0]          handle_in;
   logic [1:0]           lane_in;
   logic signed [20:0]   value_in;
   logic                 is_on;

   assign out_free = !rsp_valid || !rsp_stall;
   assign fire     = busy_ff && out_free;
   assign sel      = hold_ff.mask & (~hold_ff.mask + 6'd1);
   assign rem      = hold_ff.mask & ~sel;
   assign ready    = !busy_ff || (fire && (rem == '0));
   assign is_on    = sel[gcne_pkg::EVB_ON];

   // pick the fields of the lowest pending event
   always_comb begin
      handle_in = hold_ff.handle_new;
      lane_in   = '0;
      value_in  = '0;
      priority if (sel[gcne_pkg::EVB_OFF_OLD]) begin
         kind_in   = gcne_pkg::EV_OFF;
         handle_in = hold_ff.handle_old;
      end else if (sel[gcne_pkg::EVB_ON]) begin
         kind_in = gcne_pkg::EV_ON;
      end else if (sel[gcne_pkg::EVB_OFF_NEW]) begin
         kind_in = gcne_pkg::EV_OFF;
      end else if (sel[gcne_pkg::EVB_BEND]) begin
         kind_in  = gcne_pkg::EV_UPDATE;
         lane_in  = gcne_pkg::LN_BEND;
         value_in = hold_ff.bend_value;
      end else if (sel[gcne_pkg::EVB_PRESSURE]) begin
         kind_in  = gcne_pkg::EV_UPDATE;
         lane_in  = gcne_pkg::LN_PRESS;
         value_in = $signed(21'(hold_ff.pressure));
      end else begin
         kind_in  = gcne_pkg::EV_UPDATE;
         lane_in  = gcne_pkg::LN_TIMBRE;
         value_in = $signed(21'(hold_ff.timbre));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid           <= 1'b1;
            rsp_last            <= (rem == '0);
            rsp_event_kind      <= kind_in;
            rsp_note_handle     <= handle_in;
            rsp_lane            <= lane_in;
            rsp_update_value    <= value_in;
            rsp_note_pitch      <= is_on ? hold_ff.pitch : '0;
            rsp_note_level      <= is_on ? hold_ff.level : '0;
            rsp_note_duration   <= is_on ? hold_ff.duration : '0;
            rsp_note_pan        <= is_on ? hold_ff.pan : '0;
            rsp_note_bend_range <= is_on ? hold_ff.bend_range : '0;
         end else if (out_free) begin
            rsp_valid <= 1'b0;
         end
         if (load) begin
            busy_ff <= 1'b1;
            hold_ff <= bundle;
         end else if (fire) begin
            hold_ff.mask <= rem;
            if (rem == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   a_busy_has_events: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (hold_ff.mask != '0))
      else $error("event holder busy with no events left");

   a_off_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == gcne_pkg::EV_OFF)) |->
      (rsp_note_pitch == '0 && rsp_update_value == '0 && rsp_note_duration == '0))
      else $error("note-off carries payload");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_event_kind) && $stable(rsp_note_handle) &&
       $stable(rsp_update_value) && $stable(rsp_last)))
      else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: sv/gate_cv_to_note_events_top.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   one channel sample of gate and CV
// rsp_      out        rsp_valid/rsp_stall   note on, note off or lane update
// csr_      in         csr_write             register index and data, no read-back
//
// An item enters every cycle while the output keeps up; a stalled output holds back the
// pipeline. Results leave one per cycle unless the output stalls, and an item with
// several results holds back the next until its last one is out. The per-channel state
// lives in a 16-entry memory: read as an item enters stage 2, modified and written back
// as it leaves, with the write forwarded to a read of the same channel. A result passes
// stages 1 and 2, the event holder and the output register. Reset is synchronous;
// per-entry valid bits make the state read as zero, so there is no clearing pass.
module gate_cv_to_note_events_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_channel,
   input  wire logic               req_channel_active,
   input  wire logic signed [19:0] req_gate_volts,
   input  wire logic signed [19:0] req_pitch_volts,
   input  wire logic signed [19:0] req_level_volts,
   input  wire logic signed [19:0] req_duration_volts,
   input  wire logic signed [19:0] req_pan_volts,
   input  wire logic signed [19:0] req_pressure_volts,
   input  wire logic signed [19:0] req_timbre_volts,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_event_kind,
   output logic [31:0]             rsp_note_handle,
   output logic [1:0]              rsp_lane,
   output logic signed [20:0]      rsp_update_value,
   output logic signed [19:0]      rsp_note_pitch,
   output logic [14:0]             rsp_note_level,
   output logic [18:0]             rsp_note_duration,
   output logic signed [15:0]      rsp_note_pan,
   output logic [13:0]             rsp_note_bend_range,
   output logic                    rsp_last,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [18:0]        csr_data
);
   // configuration; bend range and the level, pan and duration defaults saturated on write
   gcne_pkg::cfg_type cfg_ff;
   logic signed [15:0] csr_pan;

   assign csr_pan = $signed(csr_data[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ends_at_gate     <= 1'b0;
         cfg_ff.bend_range       <= 14'd2048;
         cfg_ff.level_default    <= 15'd13107;
         cfg_ff.pan_default      <= '0;
         cfg_ff.duration_default <= 19'd4096;
         cfg_ff.sample_rate      <= 18'd44100;
         cfg_ff.jacks            <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            gcne_pkg::CSR_ENDS_AT_GATE: cfg_ff.ends_at_gate <= csr_data[0];
            gcne_pkg::CSR_BEND_RANGE:
               cfg_ff.bend_range <= (csr_data[13:0] > gcne_pkg::BEND_MAX) ?
                                    gcne_pkg::BEND_MAX : csr_data[13:0];
            gcne_pkg::CSR_LEVEL_DEFAULT:
               cfg_ff.level_default <= (csr_data[14:0] > gcne_pkg::FULL_Q) ?
                                       gcne_pkg::FULL_Q : csr_data[14:0];
            gcne_pkg::CSR_PAN_DEFAULT: begin
               if (csr_pan > $signed({1'b0, gcne_pkg::FULL_Q})) begin
                  cfg_ff.pan_default <= $signed({1'b0, gcne_pkg::FULL_Q});
               end else if (csr_pan < -$signed({1'b0, gcne_pkg::FULL_Q})) begin
                  cfg_ff.pan_default <= -$signed({1'b0, gcne_pkg::FULL_Q});
               end else begin
                  cfg_ff.pan_default <= csr_pan;
               end
            end
            gcne_pkg::CSR_DURATION_DEFAULT: begin
               if (csr_data < gcne_pkg::DUR_MIN_Q) begin
                  cfg_ff.duration_default <= gcne_pkg::DUR_MIN_Q;
               end else if (csr_data > gcne_pkg::DUR_MAX_Q) begin
                  cfg_ff.duration_default <= gcne_pkg::DUR_MAX_Q;
               end else begin
                  cfg_ff.duration_default <= csr_data;
               end
            end
            gcne_pkg::CSR_SAMPLE_RATE: cfg_ff.sample_rate <= csr_data[17:0];
            gcne_pkg::CSR_JACKS:       cfg_ff.jacks <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic v1_ff;
   logic v2_ff;
   logic s1_adv;
   logic s2_adv;
   logic s2_free;
   logic emit_ready;
   logic req_take;

   assign s2_adv   = v2_ff && emit_ready;
   assign s2_free  = !v2_ff || s2_adv;
   assign s1_adv   = v1_ff && s2_free;
   assign req_stall = v1_ff && !s2_free;
   assign req_take = req_valid && !req_stall;

   // stage 1: captured transfer
   gcne_pkg::item_type item1_ff;
   gcne_pkg::item_type item2_ff;
   gcne_pkg::conv_type conv1;
   gcne_pkg::conv_type conv2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_take) begin
         v1_ff <= 1'b1;
      end else if (s1_adv) begin
         v1_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item1_ff.channel  <= req_channel;
         item1_ff.active   <= req_channel_active;
         item1_ff.gate     <= req_gate_volts;
         item1_ff.pitch    <= req_pitch_volts;
         item1_ff.level    <= req_level_volts;
         item1_ff.duration <= req_duration_volts;
         item1_ff.pan      <= req_pan_volts;
         item1_ff.pressure <= req_pressure_volts;
         item1_ff.timbre   <= req_timbre_volts;
      end
   end

   gcne_conv u_conv (
      .item (item1_ff),
      .cfg  (cfg_ff),
      .conv (conv1)
   );

   // channel state memory
   gcne_pkg::chan_state_type ram_q;
   gcne_pkg::chan_state_type st_cur;
   gcne_pkg::chan_state_type st_new;
   gcne_pkg::chan_state_type fwd_word_ff;
   gcne_pkg::bundle_type     bundle;
   gcne_pkg::upd_ctl_type    ctl;
   logic [gcne_pkg::SLOTS-1:0] valid_ff;
   logic fwd_ff;
   logic rdv_ff;
   logic wr_en;

   assign wr_en = s2_adv && ctl.write;

   gcne_ram #(
      .WIDTH ($bits(gcne_pkg::chan_state_type)),
      .DEPTH (gcne_pkg::SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item2_ff.channel),
      .wr_data (st_new),
      .rd_en   (s1_adv),
      .rd_addr (item1_ff.channel),
      .rd_data (ram_q)
   );

   // stage 2: state arrives; forward a write that lands with the read
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (s1_adv) begin
            v2_ff <= 1'b1;
         end else if (s2_adv) begin
            v2_ff <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[item2_ff.channel] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         item2_ff    <= item1_ff;
         conv2_ff    <= conv1;
         fwd_ff      <= wr_en && (item2_ff.channel == item1_ff.channel);
         fwd_word_ff <= st_new;
         rdv_ff      <= valid_ff[item1_ff.channel];
      end
   end

   assign st_cur = fwd_ff ? fwd_word_ff : (rdv_ff ? ram_q : '0);

   // period-wide counters, advanced in item order
   logic [gcne_pkg::PHASE_W-1:0] phase_ff;
   logic [31:0]                  next_handle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         next_handle_ff <= 32'd1;
      end else if (s2_adv) begin
         if (ctl.rise) begin
            next_handle_ff <= next_handle_ff + 32'd1;
         end
         if (item2_ff.channel == gcne_pkg::CHAN_LAST) begin
            phase_ff <= (phase_ff == gcne_pkg::PHASE_W'(gcne_pkg::UPDATE_PERIOD - 1)) ?
                        '0 : phase_ff + 1'b1;
         end
      end
   end

   gcne_update u_update (
      .st          (st_cur),
      .item        (item2_ff),
      .conv        (conv2_ff),
      .cfg         (cfg_ff),
      .update      (phase_ff == '0),
      .next_handle (next_handle_ff),
      .st_new      (st_new),
      .bundle      (bundle),
      .ctl         (ctl)
   );

   // stage 3: hand the events out one per transfer
   gcne_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load                (s2_adv && (bundle.mask != '0)),
      .bundle              (bundle),
      .ready               (emit_ready),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_note_handle     (rsp_note_handle),
      .rsp_lane            (rsp_lane),
      .rsp_update_value    (rsp_update_value),
      .rsp_note_pitch      (rsp_note_pitch),
      .rsp_note_level      (rsp_note_level),
      .rsp_note_duration   (rsp_note_duration),
      .rsp_note_pan        (rsp_note_pan),
      .rsp_note_bend_range (rsp_note_bend_range),
      .rsp_last            (rsp_last)
   );

   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> v2_ff)
      else $error("state write without an item in stage 2");

   a_on_levels: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == gcne_pkg::EV_ON)) |->
      (rsp_note_level <= gcne_pkg::FULL_Q && rsp_note_duration >= gcne_pkg::DUR_MIN_Q))
      else $error("note-on level or duration out of range");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with stage 1 empty");
endmodule
`default_nettype wire
